[design/rgsm_pkg.sv]
// Shared constants and helper functions for the ramped gain sample mixer.
// Holds field widths, register indexes and the per-block gain ramp logic.
// No dependencies.
package rgsm_pkg;

   // Output sample width; the result wraps to this many bits.
   localparam int SAMPLE_BITS = 8;

   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 24;
   localparam int BLK_W     = 20;
   localparam int LEN_W     = 16;
   localparam int SCALE_W   = 32;
   localparam int WIN_W     = 40;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 3 * SAMPLE_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_SCALE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_ONE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TWO     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_START_ONE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_STEP_ONE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_START_TWO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_STEP_TWO  = 3'd7;

   // Reset values of the registers that do not reset to zero.
   localparam logic [LEN_W-1:0]   BLOCK_LENGTH_RST = 16'd2000;
   localparam logic [SCALE_W-1:0] SUM_SCALE_RST    = 32'd65536;

   // A channel is active on its activation block, and on any later block
   // up to and including its deactivation block.
   function automatic logic win_active(input logic [WIN_W-1:0] win,
                                       input logic [BLK_W-1:0] bc);
      logic [BLK_W-1:0] act;
      logic [BLK_W-1:0] deact;
      act   = win[BLK_W-1:0];
      deact = win[WIN_W-1:BLK_W];
      return (bc == act) || ((bc > act) && (bc <= deact));
   endfunction

   // Gain at the first sample of a block: load on activation, ramp with
   // saturation while active, otherwise hold.
   function automatic logic [GAIN_W-1:0] next_gain(input logic [WIN_W-1:0]  win,
                                                   input logic [BLK_W-1:0]  bc,
                                                   input logic [GAIN_W-1:0] gain,
                                                   input logic [GAIN_W-1:0] start,
                                                   input logic [GAIN_W-1:0] step);
      logic signed [GAIN_W+1:0] sum;
      sum = $signed({2'b00, gain}) + $signed({{2{step[GAIN_W-1]}}, step});
      if (bc == win[BLK_W-1:0]) begin
         return start;
      end else if (!win_active(win, bc)) begin
         return gain;
      end else if (sum[GAIN_W+1]) begin
         return '0;
      end else if (sum[GAIN_W]) begin
         return '1;
      end else begin
         return sum[GAIN_W-1:0];
      end
   endfunction

endpackage

[design/ramped_gain_sample_mixer_core.sv]
// Ramped gain sample mixer, top level.
// Depends on rgsm_pkg for widths, register indexes and the gain ramp helpers.
//
// Each input item carries a reference sample and two auxiliary samples. The
// block forms ref * 2^22 + aux_one * gain_one + aux_two * gain_two, scales the
// magnitude of that sum by sum_scale (Q16.16), keeps the integer part and
// restores the sign, wrapping to SAMPLE_BITS bits. Samples are counted into
// blocks of block_length; rsp_tlast marks the last sample of a block. Each
// auxiliary channel only contributes inside its block window, and its gain is
// loaded or ramped at the first sample of each active block. All four products
// go through a single 22 x 33 bit multiplier in turn under a small sequencer,
// and req_tready stays low while an item is in the sequence. A result that is
// not taken holds the sequencer in its last state until the output register
// is free. A finished result waits in the output register, so the next item
// can be accepted while it is still pending; configuration must be written
// only while the block is idle, which the block itself does not enforce.
module ramped_gain_sample_mixer_core
   import rgsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input items.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // ref_sample, aux_one_sample, aux_two_sample
   // Result items.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]  rsp_tdata,   // mixed_sample
   output logic                 rsp_tlast,   // block_end
   // Configuration writes.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIN_W-1:0]     csr_data
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MUL_ONE  = 4'd1;
   localparam logic [3:0] ST_MUL_TWO  = 4'd2;
   localparam logic [3:0] ST_ADD_TWO  = 4'd3;
   localparam logic [3:0] ST_MAG      = 4'd4;
   localparam logic [3:0] ST_MUL_LO   = 4'd5;
   localparam logic [3:0] ST_MUL_HI   = 4'd6;
   localparam logic [3:0] ST_COMBINE  = 4'd7;
   localparam logic [3:0] ST_RESULT   = 4'd8;

   localparam int ACC_W  = 42;
   localparam int MAG_W  = 41;
   localparam int MLO_W  = 21;
   localparam int MA_W   = 22;
   localparam int MB_W   = 33;
   localparam int PROD_W = MA_W + MB_W;
   localparam int LO_W   = MLO_W + SCALE_W;
   localparam int HI_W   = (MAG_W - MLO_W) + SCALE_W;
   localparam int TOT_W  = HI_W + MLO_W + 1;
   localparam int Q_LSB  = 38;

   // Configuration registers.
   logic [LEN_W-1:0]   block_length_ff;
   logic [SCALE_W-1:0] sum_scale_ff;
   logic [WIN_W-1:0]   window_one_ff, window_two_ff;
   logic [GAIN_W-1:0]  gain_start_one_ff, gain_step_one_ff;
   logic [GAIN_W-1:0]  gain_start_two_ff, gain_step_two_ff;

   // Control state.
   logic [3:0]        state_ff, state_in;
   logic [LEN_W-1:0]  sample_in_block_ff, sample_in_block_in;
   logic [BLK_W-1:0]  block_count_ff, block_count_in;
   logic [GAIN_W-1:0] gain_one_ff, gain_one_in;
   logic [GAIN_W-1:0] gain_two_ff, gain_two_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] aux_one_ff, aux_two_ff;
   logic                       act_one_ff, act_two_ff;
   logic                       end_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [LO_W-1:0]            lo_ff;
   logic [SAMPLE_BITS-1:0]     q_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_last_ff;

   logic                       accept;
   logic                       out_free;
   logic                       load_out;
   logic signed [MA_W-1:0]     mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]   mul_out;
   logic [LEN_W:0]             eff_len;
   logic                       is_end;
   logic [TOT_W-1:0]           total;
   logic [SAMPLE_BITS-1:0]     res;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_out   = (state_ff == ST_RESULT) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Block end test; a zero block length counts as one.
   assign eff_len = (block_length_ff == '0) ? (LEN_W+1)'(1) : {1'b0, block_length_ff};
   assign is_end  = ({1'b0, sample_in_block_ff} + (LEN_W+1)'(1)) >= eff_len;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_ONE: begin
            mul_a = MA_W'(aux_one_ff);
            mul_b = act_one_ff ? $signed({(MB_W-GAIN_W)'(0), gain_one_ff}) : '0;
         end
         ST_MUL_TWO: begin
            mul_a = MA_W'(aux_two_ff);
            mul_b = act_two_ff ? $signed({(MB_W-GAIN_W)'(0), gain_two_ff}) : '0;
         end
         ST_MUL_LO: begin
            mul_a = $signed({1'b0, mag_ff[MLO_W-1:0]});
            mul_b = $signed({1'b0, sum_scale_ff});
         end
         ST_MUL_HI: begin
            mul_a = $signed({2'b00, mag_ff[MAG_W-1:MLO_W]});
            mul_b = $signed({1'b0, sum_scale_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;

   // Recombine the two partial products of the magnitude times the scale.
   assign total = {1'b0, prod_ff[HI_W-1:0], MLO_W'(0)} + TOT_W'(lo_ff);

   // Restore the sign of the truncated integer part.
   assign res = neg_ff ? (SAMPLE_BITS'(0) - q_ff) : q_ff;

   // Next state of the sequencer, counters, gains and output handshake.
   always_comb begin
      state_in           = state_ff;
      sample_in_block_in = sample_in_block_ff;
      block_count_in     = block_count_ff;
      gain_one_in        = gain_one_ff;
      gain_two_in        = gain_two_ff;
      rsp_valid_in       = rsp_valid_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL_ONE;
               if (sample_in_block_ff == '0) begin
                  gain_one_in = next_gain(window_one_ff, block_count_ff, gain_one_ff,
                                          gain_start_one_ff, gain_step_one_ff);
                  gain_two_in = next_gain(window_two_ff, block_count_ff, gain_two_ff,
                                          gain_start_two_ff, gain_step_two_ff);
               end
               if (is_end) begin
                  sample_in_block_in = '0;
                  block_count_in     = block_count_ff + BLK_W'(1);
               end else begin
                  sample_in_block_in = sample_in_block_ff + LEN_W'(1);
               end
            end
         end
         ST_MUL_ONE: state_in = ST_MUL_TWO;
         ST_MUL_TWO: state_in = ST_ADD_TWO;
         ST_ADD_TWO: state_in = ST_MAG;
         ST_MAG:     state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         sample_in_block_ff <= '0;
         block_count_ff     <= '0;
         gain_one_ff        <= '0;
         gain_two_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         sample_in_block_ff <= sample_in_block_in;
         block_count_ff     <= block_count_in;
         gain_one_ff        <= gain_one_in;
         gain_two_ff        <= gain_two_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Configuration registers; an index without a register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff   <= BLOCK_LENGTH_RST;
         sum_scale_ff      <= SUM_SCALE_RST;
         window_one_ff     <= '0;
         window_two_ff     <= '0;
         gain_start_one_ff <= '0;
         gain_step_one_ff  <= '0;
         gain_start_two_ff <= '0;
         gain_step_two_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_LENGTH:   block_length_ff   <= csr_data[LEN_W-1:0];
            CSR_SUM_SCALE:      sum_scale_ff      <= csr_data[SCALE_W-1:0];
            CSR_WINDOW_ONE:     window_one_ff     <= csr_data;
            CSR_WINDOW_TWO:     window_two_ff     <= csr_data;
            CSR_GAIN_START_ONE: gain_start_one_ff <= csr_data[GAIN_W-1:0];
            CSR_GAIN_STEP_ONE:  gain_step_one_ff  <= csr_data[GAIN_W-1:0];
            CSR_GAIN_START_TWO: gain_start_two_ff <= csr_data[GAIN_W-1:0];
            CSR_GAIN_STEP_TWO:  gain_step_two_ff  <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath registers, stepped by the sequencer.
   always_ff @(posedge clock) begin
      prod_ff <= mul_out;
      if (accept) begin
         aux_one_ff <= $signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
         aux_two_ff <= $signed(req_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);
         act_one_ff <= win_active(window_one_ff, block_count_ff);
         act_two_ff <= win_active(window_two_ff, block_count_ff);
         end_ff     <= is_end;
         acc_ff     <= $signed({{(ACC_W-SAMPLE_W-22){req_tdata[SAMPLE_W-1]}},
                                req_tdata[SAMPLE_W-1:0], 22'd0});
      end
      if ((state_ff == ST_MUL_TWO) || (state_ff == ST_ADD_TWO)) begin
         acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
      end
      if (state_ff == ST_MAG) begin
         neg_ff <= acc_ff[ACC_W-1];
         mag_ff <= acc_ff[ACC_W-1] ? MAG_W'(-acc_ff) : acc_ff[MAG_W-1:0];
      end
      if (state_ff == ST_MUL_HI) begin
         lo_ff <= prod_ff[LO_W-1:0];
      end
      if (state_ff == ST_COMBINE) begin
         q_ff <= total[Q_LSB +: SAMPLE_BITS];
      end
      if (load_out) begin
         rsp_data_ff <= SAMPLE_W'(res);
         rsp_last_ff <= end_ff;
      end
   end

   // An accepted item keeps the input closed on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice in a row");

   // Bits above the sample width are always zero on a result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> SAMPLE_BITS) == '0))
      else $error("result carries bits above the sample width");

   // Gains only move when an item is accepted.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) |=> ($stable(gain_one_ff) && $stable(gain_two_ff)))
      else $error("gain changed without an accepted item");

endmodule

[tb/ramped_gain_sample_mixer_core_tb.sv]
// Self-checking testbench for the ramped gain sample mixer core.
// Drives mixer items and register writes, predicts every mixed sample and block end
// with a local model of the gain ramp, and checks each result. Depends on rgsm_pkg.
`timescale 1ns / 100ps

module ramped_gain_sample_mixer_core_tb;
   import rgsm_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS_PER_MODE = 165;

   typedef struct {
      logic [SAMPLE_W-1:0] mixed;
      logic                block_end;
   } mix_result_type;

   // Block ports, all driven to known values from time zero.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;   // ref_sample, aux_one_sample, aux_two_sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;        // mixed_sample
   logic                 rsp_tlast;        // block_end
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WIN_W-1:0]     csr_data = '0;

   // Local copy of the register file.
   logic [LEN_W-1:0]   cfg_block_length = BLOCK_LENGTH_RST;
   logic [SCALE_W-1:0] cfg_sum_scale = SUM_SCALE_RST;
   logic [WIN_W-1:0]   cfg_window [2] = '{default: '0};
   logic [GAIN_W-1:0]  cfg_gain_start [2] = '{default: '0};
   logic [GAIN_W-1:0]  cfg_gain_step [2] = '{default: '0};

   // Local copy of the block counters and channel gains.
   logic [LEN_W-1:0]  pos_in_block = '0;
   logic [BLK_W-1:0]  block_num = '0;
   logic [GAIN_W-1:0] gain_now [2] = '{default: '0};

   mix_result_type pending_mixes [$];
   int             fail_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;

   ramped_gain_sample_mixer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit, counted in clock cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each accepted result with the oldest predicted one.
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_mixes.size() == 0) begin
            $error("unexpected result item: mixed_sample %h block_end %b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_mixes.pop_front();
            if (rsp_tdata !== want.mixed) begin
               $error("mixed_sample: expected %h, got %h", want.mixed, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.block_end) begin
               $error("block_end: expected %b, got %b", want.block_end, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // A channel is live on its activation block and on later blocks up to its
   // deactivation block.
   function automatic bit channel_live(input logic [WIN_W-1:0] win);
      logic [BLK_W-1:0] act;
      logic [BLK_W-1:0] deact;
      act   = win[BLK_W-1:0];
      deact = win[WIN_W-1:BLK_W];
      return (block_num == act) || ((block_num > act) && (block_num <= deact));
   endfunction

   // Gain for a channel at the start of a block, saturated to the unsigned range.
   function automatic logic [GAIN_W-1:0] ramped_gain(input int ch);
      longint v;
      if (block_num == cfg_window[ch][BLK_W-1:0]) return cfg_gain_start[ch];
      if (!channel_live(cfg_window[ch])) return gain_now[ch];
      v = longint'(gain_now[ch]) + longint'($signed(cfg_gain_step[ch]));
      if (v < 0) v = 0;
      if (v > longint'(24'hFFFFFF)) v = longint'(24'hFFFFFF);
      return v[GAIN_W-1:0];
   endfunction

   // Work out the result of one accepted item and advance the block counters.
   task automatic predict_mix(input logic [SAMPLE_W-1:0] ref_s,
                              input logic [SAMPLE_W-1:0] aux_one_s,
                              input logic [SAMPLE_W-1:0] aux_two_s);
      logic [SAMPLE_W-1:0] aux [2];
      longint              acc;
      logic [63:0]         mag;
      logic [63:0]         quo;
      logic [95:0]         prod;
      logic [31:0]         len;
      mix_result_type      res;
      aux[0] = aux_one_s;
      aux[1] = aux_two_s;
      if (pos_in_block == 0) begin
         gain_now[0] = ramped_gain(0);
         gain_now[1] = ramped_gain(1);
      end
      // Exact Q.22 sum, then scale the magnitude and keep the integer part.
      acc = longint'($signed(ref_s)) * 4194304;
      for (int ch = 0; ch < 2; ch++) begin
         if (channel_live(cfg_window[ch]))
            acc += longint'($signed(aux[ch])) * longint'(gain_now[ch]);
      end
      mag  = (acc < 0) ? 64'(-acc) : 64'(acc);
      prod = mag * cfg_sum_scale;
      quo  = 64'(prod >> 38);
      if (acc < 0) quo = -quo;
      res.mixed = '0;
      res.mixed[SAMPLE_BITS-1:0] = quo[SAMPLE_BITS-1:0];
      // Block bookkeeping; a zero length counts as one.
      len = (cfg_block_length == 0) ? 32'd1 : 32'(cfg_block_length);
      if (32'(pos_in_block) + 32'd1 >= len) begin
         res.block_end = 1'b1;
         pos_in_block  = '0;
         block_num     = block_num + 1'b1;
      end else begin
         res.block_end = 1'b0;
         pos_in_block  = pos_in_block + 1'b1;
      end
      pending_mixes = {pending_mixes, res};
   endtask

   // Present one item, with random idle cycles ahead of it, and predict it once
   // accepted. Starts and ends at a falling edge; valid stays high afterwards.
   task automatic send_item(input logic [SAMPLE_W-1:0] ref_s,
                            input logic [SAMPLE_W-1:0] aux_one_s,
                            input logic [SAMPLE_W-1:0] aux_two_s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {aux_two_s, aux_one_s, ref_s};
      do @(posedge clock); while (!req_tready);
      predict_mix(ref_s, aux_one_s, aux_two_s);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_mixes.size() != 0) @(negedge clock);
   endtask

   // One register write, only ever issued while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BLOCK_LENGTH:   cfg_block_length  = val[LEN_W-1:0];
         CSR_SUM_SCALE:      cfg_sum_scale     = val[SCALE_W-1:0];
         CSR_WINDOW_ONE:     cfg_window[0]     = val;
         CSR_WINDOW_TWO:     cfg_window[1]     = val;
         CSR_GAIN_START_ONE: cfg_gain_start[0] = val[GAIN_W-1:0];
         CSR_GAIN_STEP_ONE:  cfg_gain_step[0]  = val[GAIN_W-1:0];
         CSR_GAIN_START_TWO: cfg_gain_start[1] = val[GAIN_W-1:0];
         CSR_GAIN_STEP_TWO:  cfg_gain_step[1]  = val[GAIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
         default: return 16'($urandom);
      endcase
   endfunction

   // Windows are placed near the current block so that they open and close
   // within the run; deactivation below activation appears on purpose.
   function automatic logic [WIN_W-1:0] random_window();
      logic [BLK_W-1:0] act;
      logic [BLK_W-1:0] deact;
      act = block_num + BLK_W'($urandom_range(0, 4));
      case ($urandom_range(0, 4))
         0: deact = act + BLK_W'($urandom_range(0, 20));
         1: deact = act - BLK_W'($urandom_range(1, 3));
         2: deact = '1;
         3: deact = BLK_W'($urandom);
         default: deact = act + BLK_W'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 9) == 0) return WIN_W'({$urandom, $urandom});
      return {deact, act};
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain_start();
      case ($urandom_range(0, 3))
         0: return 24'hFFFFFF - GAIN_W'($urandom_range(0, 4095));
         1: return GAIN_W'($urandom_range(0, 4095));
         2: return 24'h400000;
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain_step();
      logic [GAIN_W-1:0] step;
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return GAIN_W'($urandom);
         default: begin
            step = GAIN_W'($urandom_range(0, 24'h3FFFF));
            return ($urandom_range(0, 1) != 0) ? -step : step;
         end
      endcase
   endfunction

   // New settings for every register; the block must be idle here.
   task automatic write_random_settings();
      logic [LEN_W-1:0]   len;
      logic [SCALE_W-1:0] scale;
      case ($urandom_range(0, 9))
         0: len = '0;
         7, 8: len = LEN_W'($urandom_range(7, 40));
         9: len = 16'hFFFF;
         default: len = LEN_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 4))
         0: scale = 32'h00010000;
         1: scale = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'h0;
         2: scale = SCALE_W'($urandom_range(0, 32'h3FFFF));
         default: scale = $urandom;
      endcase
      write_reg(CSR_BLOCK_LENGTH, WIN_W'(len));
      write_reg(CSR_SUM_SCALE, WIN_W'(scale));
      write_reg(CSR_WINDOW_ONE, random_window());
      write_reg(CSR_WINDOW_TWO, random_window());
      write_reg(CSR_GAIN_START_ONE, WIN_W'(random_gain_start()));
      write_reg(CSR_GAIN_STEP_ONE, WIN_W'(random_gain_step()));
      write_reg(CSR_GAIN_START_TWO, WIN_W'(random_gain_start()));
      write_reg(CSR_GAIN_STEP_TWO, WIN_W'(random_gain_step()));
   endtask

   // Settings after reset: both windows open at block zero with zero gains.
   task automatic test_reset_settings();
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h8000, 16'h8000);
      send_item(16'h0001, 16'hFFFF, 16'h1234);
      wait_drained();
   endtask

   // Zero and full scale with full gains and extreme samples.
   task automatic test_scale_extremes();
      write_reg(CSR_BLOCK_LENGTH, WIN_W'(16'd1));
      write_reg(CSR_WINDOW_ONE, {20'hFFFFF, block_num + 20'd1});
      write_reg(CSR_WINDOW_TWO, {20'hFFFFF, block_num + 20'd1});
      write_reg(CSR_GAIN_START_ONE, WIN_W'(24'hFFFFFF));
      write_reg(CSR_GAIN_START_TWO, WIN_W'(24'hFFFFFF));
      write_reg(CSR_GAIN_STEP_ONE, '0);
      write_reg(CSR_GAIN_STEP_TWO, '0);
      write_reg(CSR_SUM_SCALE, '0);
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
      wait_drained();
      write_reg(CSR_SUM_SCALE, WIN_W'(32'hFFFFFFFF));
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h8000, 16'h8000);
      send_item(16'h8000, 16'h7FFF, 16'h0000);
      wait_drained();
   endtask

   // Ramps that saturate high and low, activation, and holding after the window.
   task automatic test_gain_ramp();
      write_reg(CSR_SUM_SCALE, WIN_W'(32'h00010000));
      write_reg(CSR_BLOCK_LENGTH, WIN_W'(16'd2));
      write_reg(CSR_WINDOW_ONE, {block_num + 20'd3, block_num + 20'd1});
      write_reg(CSR_GAIN_START_ONE, WIN_W'(24'hFFFFF0));
      write_reg(CSR_GAIN_STEP_ONE, WIN_W'(24'h000100));
      write_reg(CSR_WINDOW_TWO, {block_num + 20'd2, block_num});
      write_reg(CSR_GAIN_START_TWO, WIN_W'(24'h000010));
      write_reg(CSR_GAIN_STEP_TWO, WIN_W'(24'h800000));
      for (int i = 0; i < 10; i++) send_item(16'h0100, 16'h4000, 16'hC000);
      wait_drained();
   endtask

   // Zero block length, a window closing below its opening, and a length
   // lowered in the middle of a block.
   task automatic test_block_length_edges();
      write_reg(CSR_BLOCK_LENGTH, '0);
      write_reg(CSR_WINDOW_ONE, '0);
      write_reg(CSR_WINDOW_TWO, {block_num, block_num + 20'd1});
      write_reg(CSR_GAIN_START_TWO, WIN_W'(24'h400000));
      for (int i = 0; i < 3; i++) send_item(16'h0010, 16'h2000, 16'h2000);
      wait_drained();
      write_reg(CSR_BLOCK_LENGTH, WIN_W'(16'd6));
      for (int i = 0; i < 3; i++) send_item(random_sample(), random_sample(), random_sample());
      wait_drained();
      write_reg(CSR_BLOCK_LENGTH, WIN_W'(16'd2));
      for (int i = 0; i < 3; i++) send_item(random_sample(), random_sample(), random_sample());
      wait_drained();
   endtask

   // Random settings in phases, random items within each phase.
   task automatic test_random_mixing(input int send_pct, input int recv_pct);
      int sent;
      int burst;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < RANDOM_ITEMS_PER_MODE) begin
         write_random_settings();
         burst = $urandom_range(15, 40);
         for (int i = 0; i < burst; i++)
            send_item(random_sample(), random_sample(), random_sample());
         sent += burst;
         wait_drained();
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 61;
      test_reset_settings();
      test_scale_extremes();
      test_gain_ramp();
      test_block_length_edges();
      test_random_mixing(27, 61);
      test_random_mixing(61, 27);
      test_random_mixing(0, 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
